>>> hdl/ssd_pkg.sv
// ssd_pkg: shared types, constants and the 2^(k/N) table of the SSD box decoder.
// No dependencies.
package ssd_pkg;

    localparam int EXP_TABLE_ENTRIES = 256;
    localparam int TAB_BITS          = $clog2(EXP_TABLE_ENTRIES);

    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
    localparam logic [31:0] LN2_Q30   = 32'd744261118;
    localparam logic [31:0] ONE_Q30   = 32'd1073741824;

    // datapath widths
    localparam int CTR_W  = 40;   // signed centre, Q.32
    localparam int SIZE_W = 48;   // unsigned size, Q.32
    localparam int LAT    = 7;    // register stages from request to result

    typedef enum logic [1:0] {
        CFG_CENTER_VAR = 2'd0,
        CFG_SIZE_VAR   = 2'd1,
        CFG_INPUT_SIZE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] loc_x;
        logic signed [15:0] loc_y;
        logic signed [15:0] loc_w;
        logic signed [15:0] loc_h;
        logic [15:0]        prior_cx;
        logic [15:0]        prior_cy;
        logic [15:0]        prior_w;
        logic [15:0]        prior_h;
    } t_req;

    typedef struct packed {
        logic signed [15:0] box_xmin;
        logic signed [15:0] box_ymin;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
        logic               overflow;
    } t_res;

    // one axis of a finished box
    typedef struct packed {
        logic [15:0] px_min;
        logic [14:0] px_len;
        logic        ovf;
    } t_axis_res;

    typedef logic [EXP_TABLE_ENTRIES:0][31:0] t_exp_tab;

    // shift-and-subtract quotient, used only while building the table
    function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den) begin
                rem = rem - den;
                q   = q | (64'd1 << b);
            end
        end
        return q;
    endfunction

    // 2^(k/N) in Q2.30 via truncated Taylor series of exp(k*ln2/N)
    function automatic t_exp_tab build_exp_tab();
        t_exp_tab          tab;
        longint unsigned   x;
        longint unsigned   term;
        longint unsigned   sum;
        for (int k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
            x    = (longint'(k) * LN2_Q30) >> TAB_BITS;
            term = ONE_Q30;
            sum  = ONE_Q30;
            for (int i = 1; i <= 24; i++) begin
                term = div_u64((term * x) >> 30, longint'(i));
                sum  = sum + term;
            end
            tab[k] = sum[31:0];
        end
        return tab;
    endfunction

    localparam t_exp_tab EXP_TAB = build_exp_tab();

endpackage

>>> hdl/ssd_box_decoder.sv
// ssd_box_decoder: top level of the SSD box decoder pipeline.
// Depends on ssd_pkg, ssd_ctr, ssd_exp, ssd_edge.
//
// Usage
//   Request channel: a request (one predicted box plus its prior box, i_req)
//   is taken at every rising clock edge with start high and busy low. busy
//   stays low: the pipeline never stalls, so a request can be issued every
//   cycle.
//   Result channel: o_res is valid for exactly one cycle while o_strobe is
//   high. The receiver cannot stall; it must take each result as it comes.
//   Throughput: one box per cycle. Depth is set by the size path: multiply,
//   exponent multiply, 2^x table read, interpolation multiply, prior scale
//   and shift, pixel scale, saturation. Results leave in request order.
//   Config: i_cfg_we/i_cfg_idx/i_cfg_data write the center offset variance
//   (0), the size offset variance (1) and input_size (2, low 13 bits); other
//   indexes are ignored. Write only while no request is in flight.
//   Reset (synchronous, i_rst_n low): registers return to 0.1, 0.2 and
//   320; requests in flight are dropped, no strobe follows.
module ssd_box_decoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  ssd_pkg::t_req      i_req,
    output logic               o_strobe,
    output ssd_pkg::t_res      o_res,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    import ssd_pkg::*;

    logic [15:0] r_cv;
    logic [15:0] r_sv;
    logic [12:0] r_is;
    logic [LAT-1:0] r_vld;

    logic signed [CTR_W-1:0] cx;
    logic signed [CTR_W-1:0] cy;
    logic signed [CTR_W-1:0] r_cx_d [3];
    logic signed [CTR_W-1:0] r_cy_d [3];
    logic [SIZE_W-1:0]       w;
    logic [SIZE_W-1:0]       h;
    t_axis_res               res_x;
    t_axis_res               res_y;

    // never stalls
    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 16'd6554;
            r_sv <= 16'd13107;
            r_is <= 13'd320;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CENTER_VAR: r_cv <= i_cfg_data;
                CFG_SIZE_VAR:   r_sv <= i_cfg_data;
                CFG_INPUT_SIZE: r_is <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // valid bits ride alongside the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    ssd_ctr u_ctr_x (
        .i_clk(i_clk), .i_loc(i_req.loc_x), .i_prior_c(i_req.prior_cx),
        .i_prior_s(i_req.prior_w), .i_var(r_cv), .o_centre(cx)
    );
    ssd_ctr u_ctr_y (
        .i_clk(i_clk), .i_loc(i_req.loc_y), .i_prior_c(i_req.prior_cy),
        .i_prior_s(i_req.prior_h), .i_var(r_cv), .o_centre(cy)
    );

    ssd_exp u_exp_w (
        .i_clk(i_clk), .i_loc(i_req.loc_w), .i_prior_s(i_req.prior_w),
        .i_var(r_sv), .o_size(w)
    );
    ssd_exp u_exp_h (
        .i_clk(i_clk), .i_loc(i_req.loc_h), .i_prior_s(i_req.prior_h),
        .i_var(r_sv), .o_size(h)
    );

    // centre is ready 3 stages before size; line it up
    always_ff @(posedge i_clk) begin
        r_cx_d[0] <= cx;
        r_cy_d[0] <= cy;
        for (int i = 1; i < 3; i++) begin
            r_cx_d[i] <= r_cx_d[i-1];
            r_cy_d[i] <= r_cy_d[i-1];
        end
    end

    ssd_edge u_edge_x (
        .i_clk(i_clk), .i_centre(r_cx_d[2]), .i_size(w),
        .i_input_size(r_is), .o_res(res_x)
    );
    ssd_edge u_edge_y (
        .i_clk(i_clk), .i_centre(r_cy_d[2]), .i_size(h),
        .i_input_size(r_is), .o_res(res_y)
    );

    assign o_strobe          = r_vld[LAT-1];
    assign o_res.box_xmin    = $signed(res_x.px_min);
    assign o_res.box_ymin    = $signed(res_y.px_min);
    assign o_res.box_width   = res_x.px_len;
    assign o_res.box_height  = res_y.px_len;
    assign o_res.overflow    = res_x.ovf | res_y.ovf;

    // every request yields exactly one result
    a_req_to_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##7 o_strobe)
        else $error("request lost in pipeline");

    a_res_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, 7))
        else $error("result without request");

    // zero input size gives an all-zero box and no overflow
    a_zero_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && r_is == 13'd0 |->
            o_res.box_width == 15'd0 && o_res.box_height == 15'd0 &&
            o_res.box_xmin == 16'sd0 && !o_res.overflow)
        else $error("nonzero box at zero input size");
endmodule

>>> hdl/ssd_ctr.sv
// ssd_ctr: box centre, prior centre plus offset * variance * prior size, Q.32.
// Two register stages. Depends on ssd_pkg.
module ssd_ctr (
    input  logic                           i_clk,
    input  logic signed [15:0]             i_loc,
    input  logic [15:0]                    i_prior_c,
    input  logic [15:0]                    i_prior_s,
    input  logic [15:0]                    i_var,
    output logic signed [ssd_pkg::CTR_W-1:0] o_centre
);
    import ssd_pkg::*;

    logic [16:0] mag;
    logic        r_neg;
    logic [31:0] r_p1;
    logic [15:0] r_pc;
    logic [15:0] r_ps;
    logic [47:0] p2;
    logic signed [CTR_W-1:0] c_q32;
    logic signed [CTR_W-1:0] off;
    logic signed [CTR_W-1:0] n_centre;
    logic signed [CTR_W-1:0] r_centre;

    assign mag = i_loc[15] ? (17'd0 - {i_loc[15], i_loc}) : {1'b0, i_loc};

    always_ff @(posedge i_clk) begin
        r_neg <= i_loc[15];
        r_p1  <= mag[15:0] * i_var;
        r_pc  <= i_prior_c;
        r_ps  <= i_prior_s;
    end

    assign p2    = r_p1 * r_ps;
    assign off   = $signed({3'b000, p2[47:11]});
    assign c_q32 = $signed({7'd0, r_pc, 17'd0});

    always_comb begin
        n_centre = r_neg ? (c_q32 - off) : (c_q32 + off);
    end

    always_ff @(posedge i_clk) begin
        r_centre <= n_centre;
    end

    assign o_centre = r_centre;
endmodule

>>> hdl/ssd_exp.sv
// ssd_exp: box size, prior size * 2^(loc*var*log2e), table plus linear interpolation.
// Five register stages. Depends on ssd_pkg.
module ssd_exp (
    input  logic                        i_clk,
    input  logic signed [15:0]          i_loc,
    input  logic [15:0]                 i_prior_s,
    input  logic [15:0]                 i_var,
    output logic [ssd_pkg::SIZE_W-1:0]  o_size
);
    import ssd_pkg::*;

    // stage 1: loc * variance
    logic signed [32:0] r_a;
    logic [15:0]        r_ps1;
    // stage 2: exponent in Q.58, split into integer and fraction
    logic signed [65:0] t;
    logic [63:0]        u;
    logic [4:0]         r_n2;
    logic [31:0]        r_f2;
    logic [15:0]        r_ps2;
    // stage 3: table read
    logic [TAB_BITS-1:0] idx;
    logic [31:0]         lo;
    logic [31:0]         hi;
    logic [31:0]         r_lo3;
    logic [31:0]         r_diff3;
    logic [31:0]         r_r3;
    logic [4:0]          r_n3;
    logic [15:0]         r_ps3;
    // stage 4: interpolation
    logic [63:0] ip;
    logic [31:0] r_m4;
    logic [4:0]  r_n4;
    logic [15:0] r_ps4;
    // stage 5: scale and shift
    logic [47:0]       prod;
    logic [5:0]        sh;
    logic [SIZE_W-1:0] n_size;
    logic [SIZE_W-1:0] r_size;

    always_ff @(posedge i_clk) begin
        r_a   <= i_loc * $signed({1'b0, i_var});
        r_ps1 <= i_prior_s;
    end

    assign t = r_a * $signed({1'b0, LOG2E_Q30});
    assign u = t[63:0] + 64'h4000_0000_0000_0000;

    always_ff @(posedge i_clk) begin
        r_n2  <= u[62:58];
        r_f2  <= u[57:26];
        r_ps2 <= r_ps1;
    end

    assign idx = r_f2[31 -: TAB_BITS];
    assign lo  = EXP_TAB[idx];
    assign hi  = EXP_TAB[{1'b0, idx} + 1'b1];

    always_ff @(posedge i_clk) begin
        r_lo3   <= lo;
        r_diff3 <= (hi > lo) ? (hi - lo) : 32'd0;
        r_r3    <= {r_f2[31-TAB_BITS:0], {TAB_BITS{1'b0}}};
        r_n3    <= r_n2;
        r_ps3   <= r_ps2;
    end

    assign ip = r_diff3 * r_r3;

    always_ff @(posedge i_clk) begin
        r_m4  <= r_lo3 + ip[63:32];
        r_n4  <= r_n3;
        r_ps4 <= r_ps3;
    end

    // shift = 13 - (n5 - 16)
    assign prod = r_m4 * r_ps4;
    assign sh   = 6'd29 - {1'b0, r_n4};

    always_comb begin
        if (r_n4 > 5'd29) begin
            n_size = '0;
        end else begin
            n_size = prod >> sh[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_size <= n_size;
    end

    assign o_size = r_size;
endmodule

>>> hdl/ssd_edge.sv
// ssd_edge: one axis to pixels: leading edge and extent, scaled, truncated, saturated.
// Two register stages, the second is the output register. Depends on ssd_pkg.
module ssd_edge (
    input  logic                             i_clk,
    input  logic signed [ssd_pkg::CTR_W-1:0] i_centre,
    input  logic [ssd_pkg::SIZE_W-1:0]       i_size,
    input  logic [12:0]                      i_input_size,
    output ssd_pkg::t_axis_res               o_res
);
    import ssd_pkg::*;

    logic signed [49:0] x2;
    logic [48:0]        mag;
    logic               r_neg;
    logic [61:0]        r_emul;
    logic [60:0]        r_wmul;
    logic [28:0]        emag;
    logic [28:0]        wv;
    logic [16:0]        eclip;
    t_axis_res          n_res;
    t_axis_res          r_res;

    assign x2  = $signed({{9{i_centre[CTR_W-1]}}, i_centre, 1'b0}) - $signed({2'b00, i_size});
    assign mag = x2[49] ? 49'(-x2) : x2[48:0];

    always_ff @(posedge i_clk) begin
        r_neg  <= x2[49];
        r_emul <= mag * i_input_size;
        r_wmul <= i_size * i_input_size;
    end

    assign emag = r_emul[61:33];
    assign wv   = r_wmul[60:32];

    always_comb begin
        n_res = '0;
        if (r_neg) begin
            if (emag > 29'd32768) begin
                eclip     = 17'd32768;
                n_res.ovf = 1'b1;
            end else begin
                eclip = emag[16:0];
            end
            n_res.px_min = 16'(17'd0 - eclip);
        end else begin
            if (emag > 29'd32767) begin
                eclip     = 17'd32767;
                n_res.ovf = 1'b1;
            end else begin
                eclip = emag[16:0];
            end
            n_res.px_min = eclip[15:0];
        end
        if (wv > 29'd32767) begin
            n_res.px_len = 15'h7fff;
            n_res.ovf    = 1'b1;
        end else begin
            n_res.px_len = wv[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;
endmodule

>>> dv/ssd_box_decoder_chk.sv
// ssd_box_decoder_chk: watches the request, result and config ports of the box decoder,
// predicts each decoded box and compares it with what the block returns.
// Depends on ssd_pkg for the request/result structs and the register index enum.
module ssd_box_decoder_chk
    import ssd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_req        i_req,
    input  logic        i_strobe,
    input  t_res        i_res,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_boxes_owed,
    output int          o_errors
);

    logic [31:0] pow2_q30 [0:EXP_TABLE_ENTRIES];
    logic [15:0] ctr_var;
    logic [15:0] len_var;
    logic [12:0] img_size;
    t_res        boxes_due[$];
    int          errors;

    assign o_boxes_owed = boxes_due.size();
    assign o_errors     = errors;

    // 2^(k/N) in Q2.30, Taylor series of exp(k*ln2/N) through the x^24/24! term
    initial begin
        longint unsigned x, term, acc;
        for (int k = 0; k <= EXP_TABLE_ENTRIES; k++) begin
            x    = (longint'(k) * 64'd744261118) / EXP_TABLE_ENTRIES;
            term = 64'd1 << 30;
            acc  = term;
            for (int i = 1; i <= 24; i++) begin
                term = ((term * x) >> 30) / longint'(i);
                acc  = acc + term;
            end
            pow2_q30[k] = acc[31:0];
        end
    end

    // centre in Q.32
    function automatic longint centre_q32(logic signed [15:0] loc, logic [15:0] pc,
                                          logic [15:0] ps);
        longint loc_l, mag, off, c;
        loc_l = longint'(loc);
        mag   = (loc_l < 0) ? -loc_l : loc_l;
        off   = (mag * longint'({16'd0, ctr_var}) * longint'({16'd0, ps})) >>> 11;
        c     = longint'({16'd0, pc}) <<< 17;
        return (loc_l < 0) ? c - off : c + off;
    endfunction

    // size in Q.32: prior * 2^(loc*var*log2e), fraction from table + linear interp
    function automatic longint unsigned size_q32(logic signed [15:0] loc, logic [15:0] ps);
        longint          t;
        longint unsigned u, f, fn, idx, r, lo, hi, m;
        int              n;
        t   = longint'(loc) * longint'({16'd0, len_var}) * 64'sd1549082005;
        u   = unsigned'(t) + 64'h4000_0000_0000_0000;
        n   = int'(u >> 58) - 16;
        f   = (u >> 26) & 64'hFFFF_FFFF;
        fn  = f * EXP_TABLE_ENTRIES;
        idx = fn >> 32;
        r   = fn & 64'hFFFF_FFFF;
        if (idx >= EXP_TABLE_ENTRIES) idx = EXP_TABLE_ENTRIES - 1;
        lo = pow2_q30[idx];
        hi = pow2_q30[idx + 1];
        m  = lo;
        if (hi > lo) m = m + (((hi - lo) * r) >> 32);
        return (m * {48'd0, ps}) >> (13 - n);
    endfunction

    function automatic logic [15:0] edge_px(longint ctr, longint unsigned len, ref logic ovf);
        longint          x2;
        longint unsigned mag;
        x2  = 2 * ctr - longint'(len);
        mag = unsigned'((x2 < 0) ? -x2 : x2);
        mag = (mag * {51'd0, img_size}) >> 33;
        if (x2 < 0) begin
            if (mag > 32768) begin
                ovf = 1'b1;
                mag = 32768;
            end
            return 16'(-longint'(mag));
        end
        if (mag > 32767) begin
            ovf = 1'b1;
            mag = 32767;
        end
        return mag[15:0];
    endfunction

    function automatic logic [14:0] len_px(longint unsigned len, ref logic ovf);
        longint unsigned v;
        v = (len * {51'd0, img_size}) >> 32;
        if (v > 32767) begin
            ovf = 1'b1;
            v   = 32767;
        end
        return v[14:0];
    endfunction

    function automatic t_res decode_box(t_req q);
        t_res            b;
        logic            ovf;
        longint          cx, cy;
        longint unsigned w, h;
        ovf          = 1'b0;
        cx           = centre_q32(q.loc_x, q.prior_cx, q.prior_w);
        cy           = centre_q32(q.loc_y, q.prior_cy, q.prior_h);
        w            = size_q32(q.loc_w, q.prior_w);
        h            = size_q32(q.loc_h, q.prior_h);
        b.box_xmin   = edge_px(cx, w, ovf);
        b.box_ymin   = edge_px(cy, h, ovf);
        b.box_width  = len_px(w, ovf);
        b.box_height = len_px(h, ovf);
        b.overflow   = ovf;
        return b;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH t=%0t %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial errors = 0;

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            ctr_var  <= 16'd6554;
            len_var  <= 16'd13107;
            img_size <= 13'd320;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CENTER_VAR: ctr_var  <= i_cfg_data;
                    CFG_SIZE_VAR:   len_var  <= i_cfg_data;
                    CFG_INPUT_SIZE: img_size <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_strobe) begin
                if (boxes_due.size() == 0) begin
                    report("result with no request outstanding", 1, 0);
                end else begin
                    want = boxes_due.pop_front();
                    if (i_res.box_xmin !== want.box_xmin)
                        report("box_xmin", i_res.box_xmin, want.box_xmin);
                    if (i_res.box_ymin !== want.box_ymin)
                        report("box_ymin", i_res.box_ymin, want.box_ymin);
                    if (i_res.box_width !== want.box_width)
                        report("box_width", i_res.box_width, want.box_width);
                    if (i_res.box_height !== want.box_height)
                        report("box_height", i_res.box_height, want.box_height);
                    if (i_res.overflow !== want.overflow)
                        report("overflow", i_res.overflow, want.overflow);
                end
            end
            if (i_start && !i_busy)
                boxes_due = {boxes_due, decode_box(i_req)};
        end
    end

endmodule

>>> dv/ssd_box_decoder_tb.sv
// ssd_box_decoder_tb: drives box decode requests and register settings into the decoder;
// a checker beside the block predicts and compares. Depends on ssd_pkg,
// ssd_box_decoder and ssd_box_decoder_chk.
module ssd_box_decoder_tb;
    import ssd_pkg::*;

    localparam logic [1:0] CFG_NONE  = 2'd3;   // unmapped index, write must be ignored
    localparam int         LIMIT     = 400000; // cycles
    localparam int         N_PHASES  = 6;
    localparam int         PHASE_REQ = 320;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        o_strobe;
    t_res        o_res;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    int          boxes_owed;
    int          errors;
    int          cycles;
    bit          no_gaps;

    ssd_box_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_strobe   (o_strobe),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    ssd_box_decoder_chk u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_strobe     (o_strobe),
        .i_res        (o_res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_boxes_owed (boxes_owed),
        .o_errors     (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("ssd_box_decoder_tb failed");
                $finish;
            end
        end
    end

    // Issue one request; start stays high into the next request when no gap follows.
    task automatic send_box(t_req q);
        int pick, gap;
        start <= 1'b1;
        i_req <= q;
        do @(posedge i_clk); while (busy);
        pick = $urandom_range(99);
        gap  = 0;
        if (!no_gaps) begin
            if (pick >= 95)      gap = $urandom_range(40, 8);
            else if (pick >= 60) gap = $urandom_range(3, 1);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // one write, then write enable drops before the task returns so back-to-back calls never collide
    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Let the pipe empty before touching registers.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (boxes_owed != 0) @(posedge i_clk);
        repeat (LAT + 3) @(posedge i_clk);
    endtask

    function automatic t_req mk_box(logic [15:0] lx, logic [15:0] ly, logic [15:0] lw,
                                    logic [15:0] lh, logic [15:0] cx, logic [15:0] cy,
                                    logic [15:0] pw, logic [15:0] ph);
        t_req q;
        q.loc_x = lx; q.loc_y = ly; q.loc_w = lw; q.loc_h = lh;
        q.prior_cx = cx; q.prior_cy = cy; q.prior_w = pw; q.prior_h = ph;
        return q;
    endfunction

    // Offsets: mostly full range, some near zero where sizes stay sane.
    function automatic logic [15:0] rand_loc();
        if ($urandom_range(9) < 7) return 16'($urandom);
        return 16'($urandom_range(8192) - 4096);
    endfunction

    // Priors: mostly in the unit image, sometimes anything the field can carry.
    function automatic logic [15:0] rand_prior();
        if ($urandom_range(99) < 85) return 16'($urandom_range(32768));
        return 16'($urandom);
    endfunction

    function automatic t_req rand_box();
        return mk_box(rand_loc(), rand_loc(), rand_loc(), rand_loc(),
                      rand_prior(), rand_prior(), rand_prior(), rand_prior());
    endfunction

    initial begin
        logic [15:0] cv_set [N_PHASES];
        logic [15:0] sv_set [N_PHASES];
        logic [15:0] is_set [N_PHASES];
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_CENTER_VAR;
        i_cfg_data = '0;
        no_gaps    = 1'b0;
        cv_set = '{16'd6554, 16'd0,     16'd65535, 16'd65535, 16'd0,     16'($urandom)};
        sv_set = '{16'd13107, 16'd0,    16'd65535, 16'd0,     16'd65535, 16'($urandom)};
        is_set = '{16'd320,   16'd1,    16'd4096,  16'd8191,  16'd0,
                   16'($urandom_range(4096, 1))};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset register values: zero offsets, extremes of offsets and priors
        send_box(mk_box(16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd16384, 16'd8192, 16'd8192));
        send_box(mk_box(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                        16'd0, 16'd0, 16'd32768, 16'd32768));
        send_box(mk_box(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                        16'd32768, 16'd32768, 16'd32768, 16'd32768));
        send_box(mk_box(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF,
                        16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_box(mk_box(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
                        16'd0, 16'hFFFF, 16'd0, 16'hFFFF));
        send_box(mk_box(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001,
                        16'd1, 16'd32767, 16'd1, 16'd32767));
        send_box(mk_box(16'h1000, 16'hF000, 16'h2000, 16'hE000,
                        16'd32768, 16'd0, 16'd16384, 16'd16384));
        send_box(mk_box(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                        16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        send_box(mk_box(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                        16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        drain();
        // unmapped index is ignored; then a request to prove defaults survived
        write_reg(CFG_NONE, 16'hFFFF);
        send_box(mk_box(16'h7FFF, 16'h8000, 16'h4000, 16'hC000,
                        16'd16384, 16'd16384, 16'd16384, 16'd16384));
        drain();

        // phases with different register settings, extremes included
        for (int p = 0; p < N_PHASES; p++) begin
            write_reg(CFG_CENTER_VAR, cv_set[p]);
            write_reg(CFG_SIZE_VAR,   sv_set[p]);
            write_reg(CFG_INPUT_SIZE, is_set[p]);
            no_gaps = (p == 2);   // one back-to-back stretch at full rate
            for (int k = 0; k < PHASE_REQ; k++)
                send_box(rand_box());
            if (p == 0)
                for (int k = 0; k < 6; k++)   // zero-size and huge priors at this setting
                    send_box(mk_box(rand_loc(), rand_loc(), rand_loc(), rand_loc(),
                                    16'd0, 16'hFFFF, 16'(k[0] ? 0 : 65535), 16'd32768));
            drain();
        end

        if (errors == 0 && boxes_owed == 0) begin
            $display("ssd_box_decoder_tb passed");
        end else begin
            $display("ssd_box_decoder_tb failed");
        end
        $finish;
    end

endmodule
